// ===== src/uxcal_pkg.sv =====
package uxcal_pkg;

	// Reciprocal constants for division by constants: q = (n * M) >> S.
	// Each pair is exact over the full range of its operand in the pipeline.
	localparam logic [31:0] DIV60_M   = 32'h8888_8889;
	localparam int          DIV60_S   = 37;
	localparam logic [21:0] DIV24_M   = 22'd2796203;
	localparam int          DIV24_S   = 26;
	localparam logic [16:0] DIV7_M    = 17'd74899;
	localparam int          DIV7_S    = 19;
	localparam logic [16:0] DIV1461_M = 17'd91868;
	localparam int          DIV1461_S = 27;
	localparam logic [16:0] DIV365_M  = 17'd91930;
	localparam int          DIV365_S  = 25;

	// Calendar constants
	localparam logic [11:0] BASE_YEAR      = 12'd1968;
	localparam logic [15:0] DAYS_TO_1970   = 16'd731;
	localparam logic [15:0] DAYS_PER_CYCLE = 16'd1461;
	localparam logic [10:0] DAYS_JAN_FEB   = 11'd59;
	localparam logic [15:0] DAYS_PER_YEAR  = 16'd365;
	localparam logic [16:0] EPOCH_WEEKDAY  = 17'd4;
	localparam int          MONTHS         = 12;
	localparam logic [3:0]  MONTHS_EARLY   = 4'd2;
	localparam logic [3:0]  MONTHS_ALL     = 4'd12;

	// Days before the start of each month in a common year
	function automatic logic [8:0] month_start(input logic [3:0] idx);
		logic [8:0] d;
		case (idx)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// ===== src/unix_seconds_to_calendar.sv =====
// Channel   Direction  Handshake               Payload
// -------   ---------  ----------------------  ----------------------------------------
// command   in         start && !busy          epoch_seconds[31:0]
// result    out        done (one-cycle strobe) second, minute, hour, weekday, year,
//                                              month, day_of_month
//
// One beat enters per cycle; each result leaves once its beat has passed every stage.
// The latency is set by the chain of constant divisions (60, 60, 24, 1461, 365),
// each split into a multiply stage and a remainder stage.
// busy is held low: the receiver cannot stall, so nothing ever backs up.
// arst_n clears the valid bits only; payload registers carry no reset.
module unix_seconds_to_calendar
	import uxcal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [5:0]  second,
	output logic [5:0]  minute,
	output logic [4:0]  hour,
	output logic [2:0]  weekday,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month
);

	localparam int LATENCY = 9;

	logic [LATENCY:1] v_s;

	// stage 1
	logic [31:0] t_s1;
	logic [26:0] qmin_s1;
	// stage 2
	logic [5:0]  sec_s2;
	logic [26:0] qmin_s2;
	logic [20:0] qhr_s2;
	// stage 3
	logic [5:0]  sec_s3, min_s3;
	logic [20:0] qhr_s3;
	logic [15:0] days_s3;
	// stage 4
	logic [5:0]  sec_s4, min_s4;
	logic [4:0]  hr_s4;
	logic [15:0] d4_s4, daysx_s4;
	logic [12:0] wdq_s4;
	logic [5:0]  cyc_s4;
	// stage 5
	logic [5:0]  sec_s5, min_s5;
	logic [4:0]  hr_s5;
	logic [2:0]  wday_s5;
	logic [15:0] daysx_s5;
	logic [10:0] rem_s5;
	logic [5:0]  cyc_s5;
	// stage 6
	logic [5:0]  sec_s6, min_s6;
	logic [4:0]  hr_s6;
	logic [2:0]  wday_s6;
	logic [15:0] dl_s6;
	logic        late_s6;
	// stage 7
	logic [5:0]  sec_s7, min_s7;
	logic [4:0]  hr_s7;
	logic [2:0]  wday_s7;
	logic [15:0] dl_s7;
	logic [7:0]  yoff_s7;
	logic        late_s7;
	// stage 8
	logic [5:0]  sec_s8, min_s8;
	logic [4:0]  hr_s8;
	logic [2:0]  wday_s8;
	logic [8:0]  doy_s8;
	logic [11:0] year_s8;
	logic        late_s8;
	// stage 9
	logic [5:0]  sec_s9, min_s9;
	logic [4:0]  hr_s9;
	logic [2:0]  wday_s9;
	logic [11:0] year_s9;
	logic [3:0]  month_s9;
	logic [4:0]  mday_s9;

	// reciprocal products
	logic [63:0] p_min;
	logic [58:0] p_hr;
	logic [42:0] p_day;
	logic [33:0] p_wd;
	logic [33:0] p_cyc;
	logic [32:0] p_yr;
	logic [16:0] d4_c;
	logic [15:0] daysx_c;
	logic        late_c;
	logic [5:0]  leaps_c;
	logic [3:0]  limit_c;
	logic [3:0]  month_c;
	logic [8:0]  mstart_c;

	assign busy = 1'b0;

	// advance the valid bits, one per stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[LATENCY-1:1], start & ~busy};
		end
	end

	// stage 1: seconds / 60
	assign p_min = 64'(epoch_seconds) * 64'(DIV60_M);

	always_ff @(posedge clk) begin
		t_s1    <= epoch_seconds;
		qmin_s1 <= p_min[DIV60_S+26:DIV60_S];
	end

	// stage 2: second remainder, minutes / 60
	assign p_hr = 59'(qmin_s1) * 59'(DIV60_M);

	always_ff @(posedge clk) begin
		sec_s2  <= 6'(t_s1 - 32'(qmin_s1) * 32'd60);
		qmin_s2 <= qmin_s1;
		qhr_s2  <= p_hr[DIV60_S+20:DIV60_S];
	end

	// stage 3: minute remainder, hours / 24
	assign p_day = 43'(qhr_s2) * 43'(DIV24_M);

	always_ff @(posedge clk) begin
		sec_s3  <= sec_s2;
		min_s3  <= 6'(qmin_s2 - 27'(qhr_s2) * 27'd60);
		qhr_s3  <= qhr_s2;
		days_s3 <= p_day[DIV24_S+15:DIV24_S];
	end

	// stage 4: hour remainder, weekday and four-year cycle quotients
	assign d4_c    = 17'(days_s3) + EPOCH_WEEKDAY;
	assign daysx_c = days_s3 + DAYS_TO_1970;
	assign p_wd    = 34'(d4_c) * 34'(DIV7_M);
	assign p_cyc   = 34'(daysx_c) * 34'(DIV1461_M);

	always_ff @(posedge clk) begin
		sec_s4   <= sec_s3;
		min_s4   <= min_s3;
		hr_s4    <= 5'(qhr_s3 - 21'(days_s3) * 21'd24);
		d4_s4    <= d4_c[15:0];
		daysx_s4 <= daysx_c;
		wdq_s4   <= p_wd[DIV7_S+12:DIV7_S];
		cyc_s4   <= p_cyc[DIV1461_S+5:DIV1461_S];
	end

	// stage 5: weekday remainder, day within the four-year cycle
	always_ff @(posedge clk) begin
		sec_s5   <= sec_s4;
		min_s5   <= min_s4;
		hr_s5    <= hr_s4;
		wday_s5  <= 3'(d4_s4 - 16'(wdq_s4) * 16'd7);
		daysx_s5 <= daysx_s4;
		rem_s5   <= 11'(daysx_s4 - 16'(cyc_s4) * DAYS_PER_CYCLE);
		cyc_s5   <= cyc_s4;
	end

	// stage 6: count the leap day once past February of the cycle's first year
	assign late_c  = rem_s5 > DAYS_JAN_FEB;
	assign leaps_c = cyc_s5 + 6'(late_c);

	always_ff @(posedge clk) begin
		sec_s6  <= sec_s5;
		min_s6  <= min_s5;
		hr_s6   <= hr_s5;
		wday_s6 <= wday_s5;
		dl_s6   <= daysx_s5 - 16'(leaps_c);
		late_s6 <= late_c;
	end

	// stage 7: leap-free days / 365
	assign p_yr = 33'(dl_s6) * 33'(DIV365_M);

	always_ff @(posedge clk) begin
		sec_s7  <= sec_s6;
		min_s7  <= min_s6;
		hr_s7   <= hr_s6;
		wday_s7 <= wday_s6;
		dl_s7   <= dl_s6;
		yoff_s7 <= p_yr[DIV365_S+7:DIV365_S];
		late_s7 <= late_s6;
	end

	// stage 8: day of year and year
	always_ff @(posedge clk) begin
		sec_s8  <= sec_s7;
		min_s8  <= min_s7;
		hr_s8   <= hr_s7;
		wday_s8 <= wday_s7;
		doy_s8  <= 9'(dl_s7 - 16'(yoff_s7) * DAYS_PER_YEAR);
		year_s8 <= 12'(yoff_s7) + BASE_YEAR;
		late_s8 <= late_s7;
	end

	// stage 9: month lookup, limited to Jan/Feb early in the leap year
	assign limit_c = late_s8 ? MONTHS_ALL : MONTHS_EARLY;

	always_comb begin
		month_c = 4'd1;
		for (int i = 0; i < MONTHS; i++) begin
			if (4'(i) < limit_c && month_start(4'(i)) <= doy_s8) begin
				month_c = 4'(i + 1);
			end
		end
	end

	assign mstart_c = month_start(month_c - 4'd1);

	always_ff @(posedge clk) begin
		sec_s9   <= sec_s8;
		min_s9   <= min_s8;
		hr_s9    <= hr_s8;
		wday_s9  <= wday_s8;
		year_s9  <= year_s8;
		month_s9 <= month_c;
		mday_s9  <= 5'(doy_s8 - mstart_c + 9'd1);
	end

	assign done         = v_s[LATENCY];
	assign second       = sec_s9;
	assign minute       = min_s9;
	assign hour         = hr_s9;
	assign weekday      = wday_s9;
	assign year         = year_s9;
	assign month        = month_s9;
	assign day_of_month = mday_s9;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a beat taken %0d cycles earlier", LATENCY);

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (second < 6'd60 && minute < 6'd60 && hour < 5'd24 && weekday < 3'd7))
		else $error("time of day or weekday out of range");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& year >= 12'd1970 && year <= 12'd2106))
		else $error("calendar date out of range");

	a_february: assert property (@(posedge clk) disable iff (!arst_n)
		(done && month == 4'd2) |-> (day_of_month <= 5'd29))
		else $error("February day past the 29th");
`endif

endmodule

// ===== test/uxcal_checker.sv =====
`timescale 1ns / 100ps

module uxcal_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [31:0] epoch_seconds,
	input  logic        done,
	input  logic [5:0]  second,
	input  logic [5:0]  minute,
	input  logic [4:0]  hour,
	input  logic [2:0]  weekday,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day_of_month,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [2:0]  weekday;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
	} calendar_t;

	localparam int unsigned CYCLE_DAYS   = 4 * 365 + 1;
	localparam int unsigned EPOCH_OFFSET = 366 + 365;
	localparam int unsigned JAN_FEB_DAYS = 31 + 28;
	localparam int unsigned FIRST_YEAR   = 1968;
	localparam int unsigned THURSDAY     = 4;
	localparam int unsigned MONTH_FIRST_DAY [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	calendar_t expected_dates[$];

	// Split a seconds count into time of day, weekday and calendar date
	function automatic calendar_t to_calendar(input logic [31:0] secs);
		int unsigned t, days, leaps, rem, yr, doy, month_limit, m;
		bit found;
		calendar_t c;
		t = secs;
		c.second = 6'(t % 60);
		t = t / 60;
		c.minute = 6'(t % 60);
		t = t / 60;
		c.hour = 5'(t % 24);
		days = t / 24;
		c.weekday = 3'((days + THURSDAY) % 7);

		// count leap days from 1968; this cycle's leap day counts only past February
		days = days + EPOCH_OFFSET;
		leaps = days / CYCLE_DAYS;
		rem = days % CYCLE_DAYS;
		if (rem > JAN_FEB_DAYS) begin
			leaps = leaps + 1;
			month_limit = 12;
		end else begin
			month_limit = 2;
		end
		yr = (days - leaps) / 365 + FIRST_YEAR;
		doy = days - ((yr - FIRST_YEAR) * 365 + leaps);

		// find the first month that starts after the day of year
		m = month_limit;
		found = 1'b0;
		for (int i = 0; i < month_limit; i++) begin
			if (!found && MONTH_FIRST_DAY[i] > doy) begin
				m = i;
				found = 1'b1;
			end
		end
		c.year = 12'(yr);
		c.month = 4'(m);
		c.day_of_month = 5'(doy - MONTH_FIRST_DAY[m - 1] + 1);
		return c;
	endfunction

	task automatic check_field(input string field, input int exp_val, input int act_val);
		if (exp_val != act_val) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d, got %0d",
				$time, field, exp_val, act_val);
		end
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Compare each result beat with the oldest prediction, then log new commands
	always @(posedge clk) begin
		calendar_t exp_date;
		if (arst_n) begin
			if (done) begin
				if (expected_dates.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with no command outstanding, got %0d-%0d-%0d",
						$time, year, month, day_of_month);
				end else begin
					exp_date = expected_dates.pop_front();
					check_field("second", exp_date.second, second);
					check_field("minute", exp_date.minute, minute);
					check_field("hour", exp_date.hour, hour);
					check_field("weekday", exp_date.weekday, weekday);
					check_field("year", exp_date.year, year);
					check_field("month", exp_date.month, month);
					check_field("day_of_month", exp_date.day_of_month, day_of_month);
				end
			end
			if (start && !busy)
				expected_dates.push_back(to_calendar(epoch_seconds));
			pending <= expected_dates.size();
		end
	end

endmodule

// ===== test/tb_unix_seconds_to_calendar.sv =====
`timescale 1ns / 100ps

module tb_unix_seconds_to_calendar;

	localparam int RANDOM_BEATS   = 1100;
	localparam int QUIET_FIRST    = 400;
	localparam int QUIET_LAST     = 650;
	localparam int STALL_LIMIT    = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int LAST_DAY       = 49710;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] epoch_seconds;
	logic        done;
	logic [5:0]  second;
	logic [5:0]  minute;
	logic [4:0]  hour;
	logic [2:0]  weekday;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;

	int  fail_count;
	int  pending;
	int  stall_cycles;
	bit  quiet;

	unix_seconds_to_calendar dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.done         (done),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.weekday      (weekday),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month)
	);

	uxcal_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.done         (done),
		.second       (second),
		.minute       (minute),
		.hour         (hour),
		.weekday      (weekday),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.fail_count   (fail_count),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort when no beat moves on either side for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else
			stall_cycles <= stall_cycles + 1;
	end

	// Offer one timestamp, with an occasional idle cycle first; return at a falling edge
	task automatic send_time(input logic [31:0] value);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 16)
			gap = 1;
		if (gap > 0) begin
			start <= 1'b0;
			epoch_seconds <= $urandom;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		epoch_seconds <= value;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Pick a timestamp near a leap-day, year or midnight boundary, or anywhere
	function automatic logic [31:0] pick_time();
		int unsigned days, cycle, offset;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5, 6: begin
				cycle = $urandom_range(1, 33);
				offset = $urandom_range(55, 65) + 365 * $urandom_range(0, 3);
				days = 1461 * cycle + offset - 731;
				return days * 86400 + $urandom_range(0, 86399);
			end
			7, 8: begin
				cycle = $urandom_range(1, 33);
				offset = $urandom_range(0, 3) * 365 + $urandom_range(0, 1) * 364
					+ $urandom_range(0, 1);
				days = 1461 * cycle + offset - 731;
				if ($urandom_range(0, 1))
					return days * 86400 + $urandom_range(86390, 86399);
				return days * 86400 + $urandom_range(0, 9);
			end
			default: begin
				days = $urandom_range(0, LAST_DAY - 1);
				return days * 86400 + $urandom_range(0, 86399);
			end
		endcase
	endfunction

	initial begin
		logic [31:0] directed [25];
		directed = '{
			32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd86399, 32'd86400,
			32'd5097599, 32'd5097600,
			32'd68169599, 32'd68169600, 32'd68255999, 32'd68256000,
			32'd94694399, 32'd94694400,
			32'd946684799, 32'd946684800, 32'd951782400, 32'd951868800,
			32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
			32'd4107456000, 32'd4107542400
		};
		arst_n = 1'b0;
		start = 1'b0;
		epoch_seconds = '0;
		quiet = 1'b0;
		stall_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Edges of the range, month and leap-day boundaries, the 2100 quirk
		foreach (directed[i])
			send_time(directed[i]);

		// Random beats, with one stretch of back-to-back traffic
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			quiet = (n >= QUIET_FIRST && n < QUIET_LAST);
			send_time(pick_time());
		end
		start <= 1'b0;

		// Drain the pipeline
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
